// File: rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent property checked on every rising edge outside reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Expression that must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
  `ASSERT_PROP(lbl, clk, rst_n, !(expr))

`endif

// File: rtl/cpbc_pkg.sv
// Types and codes of the pileup base counter.
`default_nettype none
package cpbc_pkg;

  localparam int CntW     = 32;
  localparam int NumCnt   = 8;
  localparam int TargetW  = 31;
  localparam int CursorW  = 32;
  localparam int LenW     = 28;
  localparam int WordW    = 64;

  localparam logic [1:0] CMD_START  = 2'd0;
  localparam logic [1:0] CMD_LOAD   = 2'd1;
  localparam logic [1:0] CMD_CIGAR  = 2'd2;
  localparam logic [1:0] CMD_REPORT = 2'd3;

  localparam logic [3:0] OP_M   = 4'd0;
  localparam logic [3:0] OP_I   = 4'd1;
  localparam logic [3:0] OP_D   = 4'd2;
  localparam logic [3:0] OP_N   = 4'd3;
  localparam logic [3:0] OP_S   = 4'd4;
  localparam logic [3:0] OP_EQ  = 4'd7;
  localparam logic [3:0] OP_X   = 4'd8;

  localparam logic [1:0] CFG_TARGET  = 2'd0;
  localparam logic [1:0] CFG_MIN_MQ  = 2'd1;
  localparam logic [1:0] CFG_REJ_MSK = 2'd2;

  localparam int CNT_A    = 0;
  localparam int CNT_C    = 1;
  localparam int CNT_G    = 2;
  localparam int CNT_T    = 3;
  localparam int CNT_INS  = 4;
  localparam int CNT_DEL  = 5;
  localparam int CNT_COV  = 6;
  localparam int CNT_SEEN = 7;

  localparam logic [3:0] BASE_A = 4'd1;
  localparam logic [3:0] BASE_C = 4'd2;
  localparam logic [3:0] BASE_G = 4'd4;
  localparam logic [3:0] BASE_T = 4'd8;

  typedef logic [NumCnt-1:0][CntW-1:0] cnt_vec_t;

  typedef struct packed {
    logic       valid;
    logic       report;
    logic       seen;
    logic       cov;
    logic       ins;
    logic       del;
    logic       base_chk;
    logic [3:0] nib_pos;
  } event_t;

endpackage
`default_nettype wire

// File: rtl/cpbc_seq_store.sv
// Read sequence word memory with registered read.
`default_nettype none
module cpbc_seq_store #(
  parameter int Slots = 16,
  parameter int AddrW = 4
) (
  input  wire logic                      clk,
  input  wire logic                      we,
  input  wire logic [AddrW-1:0]          waddr,
  input  wire logic [cpbc_pkg::WordW-1:0] wdata,
  input  wire logic                      re,
  input  wire logic [AddrW-1:0]          raddr,
  output      logic [cpbc_pkg::WordW-1:0] rdata
);
  import cpbc_pkg::*;

  logic [WordW-1:0] mem [Slots];
  logic [WordW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// File: rtl/cpbc_walker.sv
// Configuration, read cursors and cigar walk; issues store accesses and count events.
`default_nettype none
module cpbc_walker #(
  parameter int Slots     = 16,
  parameter int AddrW     = 4,
  parameter int BaseLimit = 256
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_we,
  input  wire logic [1:0]                   cfg_index,
  input  wire logic [31:0]                  cfg_data,
  input  wire logic                         accept,
  input  wire logic                         adv,
  input  wire logic [1:0]                   command,
  input  wire logic [cpbc_pkg::TargetW-1:0] align_start,
  input  wire logic [7:0]                   map_quality,
  input  wire logic [15:0]                  read_flags,
  input  wire logic [3:0]                   word_index,
  input  wire logic [3:0]                   op_code,
  input  wire logic [cpbc_pkg::LenW-1:0]    op_length,
  output      logic                         st_we,
  output      logic [AddrW-1:0]             st_waddr,
  output      logic                         st_re,
  output      logic [AddrW-1:0]             st_raddr,
  output      cpbc_pkg::event_t             ev
);
  import cpbc_pkg::*;

  logic [TargetW-1:0] target_r;
  logic [7:0]         min_mq_r;
  logic [15:0]        rej_mask_r;
  logic [CursorW-1:0] ref_cur_r, ref_cur_nxt;
  logic [CursorW-1:0] read_cur_r, read_cur_nxt;
  logic               skip_r, skip_nxt;
  event_t             ev_r, ev_nxt;

  logic [CursorW:0]   ref_sum, read_sum, pos;
  logic [CursorW-1:0] ref_sat, read_sat, diff;
  logic               covers, base_ok, at_target, is_cigar;

  always_comb begin
    ref_sum   = {1'b0, ref_cur_r} + {{(CursorW-LenW+1){1'b0}}, op_length};
    read_sum  = {1'b0, read_cur_r} + {{(CursorW-LenW+1){1'b0}}, op_length};
    ref_sat   = ref_sum[CursorW] ? '1 : ref_sum[CursorW-1:0];
    read_sat  = read_sum[CursorW] ? '1 : read_sum[CursorW-1:0];
    covers    = ({1'b0, ref_cur_r} <= {2'b0, target_r}) && ({2'b0, target_r} < ref_sum);
    at_target = (ref_cur_r == {1'b0, target_r});
    diff      = {1'b0, target_r} - ref_cur_r;
    pos       = {1'b0, read_cur_r} + {1'b0, diff};
    base_ok   = (pos < (CursorW+1)'(BaseLimit));
    is_cigar  = accept && (command == CMD_CIGAR) && !skip_r;
  end

  always_comb begin
    ref_cur_nxt  = ref_cur_r;
    read_cur_nxt = read_cur_r;
    skip_nxt     = skip_r;
    ev_nxt       = '0;
    st_re        = 1'b0;
    st_raddr     = pos[4 +: AddrW];
    st_we        = accept && (command == CMD_LOAD) && ({1'b0, word_index} < 5'(Slots));
    st_waddr     = word_index[AddrW-1:0];
    ev_nxt.valid   = accept;
    ev_nxt.nib_pos = pos[3:0];
    if (accept) begin
      unique case (command)
        CMD_START: begin
          ev_nxt.seen  = 1'b1;
          ref_cur_nxt  = {1'b0, align_start};
          read_cur_nxt = '0;
          skip_nxt     = (map_quality < min_mq_r) || ((read_flags & rej_mask_r) != '0);
        end
        CMD_REPORT: ev_nxt.report = 1'b1;
        default: ;
      endcase
    end
    if (is_cigar) begin
      unique case (op_code)
        OP_M, OP_EQ, OP_X: begin
          ev_nxt.cov      = covers;
          ev_nxt.base_chk = covers && base_ok;
          st_re           = covers && base_ok;
          ref_cur_nxt     = ref_sat;
          read_cur_nxt    = read_sat;
        end
        OP_I: begin
          ev_nxt.ins   = at_target;
          read_cur_nxt = read_sat;
        end
        OP_D: begin
          ev_nxt.del  = covers;
          ref_cur_nxt = ref_sat;
        end
        OP_N: ref_cur_nxt  = ref_sat;
        OP_S: read_cur_nxt = read_sat;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r   <= '0;
      min_mq_r   <= '0;
      rej_mask_r <= '0;
      ref_cur_r  <= '0;
      read_cur_r <= '0;
      skip_r     <= 1'b1;
      ev_r       <= '0;
    end else begin
      if (cfg_we) begin
        priority case (cfg_index)
          CFG_TARGET:  target_r   <= cfg_data[TargetW-1:0];
          CFG_MIN_MQ:  min_mq_r   <= cfg_data[7:0];
          CFG_REJ_MSK: rej_mask_r <= cfg_data[15:0];
          default: ;
        endcase
      end
      ref_cur_r  <= ref_cur_nxt;
      read_cur_r <= read_cur_nxt;
      skip_r     <= skip_nxt;
      if (adv) begin
        ev_r <= ev_nxt;
      end
    end
  end

  assign ev = ev_r;

endmodule
`default_nettype wire

// File: rtl/cpbc_counters.sv
// Saturating counter bank and registered report output.
`default_nettype none
module cpbc_counters (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire cpbc_pkg::event_t             ev,
  input  wire logic [cpbc_pkg::WordW-1:0]   rd_word,
  output      logic                         ev_done,
  output      logic                         out_valid,
  input  wire logic                         out_ready,
  output      cpbc_pkg::cnt_vec_t           out_counts
);
  import cpbc_pkg::*;

  cnt_vec_t          cnt_r, cnt_nxt;
  cnt_vec_t          out_r;
  logic              out_valid_r;
  logic              fire;
  logic [3:0]        base;
  logic [NumCnt-1:0] inc;

  always_comb begin
    ev_done = !ev.report || !out_valid_r || out_ready;
    fire    = ev.valid && ev_done;
    base    = rd_word[{~ev.nib_pos, 2'b00} +: 4];
    inc     = '0;
    inc[CNT_A]    = ev.base_chk && (base == BASE_A);
    inc[CNT_C]    = ev.base_chk && (base == BASE_C);
    inc[CNT_G]    = ev.base_chk && (base == BASE_G);
    inc[CNT_T]    = ev.base_chk && (base == BASE_T);
    inc[CNT_INS]  = ev.ins;
    inc[CNT_DEL]  = ev.del;
    inc[CNT_COV]  = ev.cov;
    inc[CNT_SEEN] = ev.seen;
    for (int i = 0; i < NumCnt; i++) begin
      if (fire && ev.report) begin
        cnt_nxt[i] = '0;
      end else if (fire && inc[i] && (cnt_r[i] != '1)) begin
        cnt_nxt[i] = cnt_r[i] + CntW'(1);
      end else begin
        cnt_nxt[i] = cnt_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (fire && ev.report) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && ev.report) begin
      out_r <= cnt_r;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_counts = out_r;

endmodule
`default_nettype wire

// File: rtl/cigar_pileup_base_counter.sv
// Top level of the pileup base counter at one reference position.
//
//  channel | direction | handshake           | payload
//  in_     | slave     | in_tvalid/in_tready | in_tdata (fields), in_tuser (command)
//  out_    | master    | out_tvalid/tready   | out_tdata (eight 32-bit counters)
//  cfg_    | slave     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// One item per cycle while in_tready is high; each item passes one cursor stage and one count stage.
// A report item is registered as an event in the walker, then its result is registered in the counter bank.
// A cigar match over the target reads the sequence store at accept; the word arrives in the next cycle, with its event.
// in_tready drops only while a report waits behind an unaccepted result.
// Reset is synchronous; no clearing pass, the sequence store is not cleared.
`default_nettype none
module cigar_pileup_base_counter #(
  parameter int MAX_READ_BASES = 256
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output      logic         in_tready,
  // [30:0] align_start, [38:31] map_quality, [54:39] read_flags, [58:55] word_index,
  // [122:59] base_word, [126:123] op_code, [154:127] op_length, [159:155] zero
  input  wire logic [159:0] in_tdata,
  // [1:0] command
  input  wire logic [1:0]   in_tuser,
  output      logic         out_tvalid,
  input  wire logic         out_tready,
  // [31:0] count_a, [63:32] count_c, [95:64] count_g, [127:96] count_t,
  // [159:128] count_ins, [191:160] count_del, [223:192] covered_reads,
  // [255:224] reads_seen
  output      logic [255:0] out_tdata,
  input  wire logic         cfg_valid,
  output      logic         cfg_ready,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [31:0]  cfg_data
);
  import cpbc_pkg::*;

  localparam int StoreWords = (MAX_READ_BASES + 15) / 16;
  localparam int Slots      = (StoreWords < 16) ? StoreWords : 16;
  localparam int AddrW      = (Slots > 1) ? $clog2(Slots) : 1;
  localparam int BaseLimit  = (MAX_READ_BASES < 256) ? MAX_READ_BASES : 256;

  logic             accept, adv, ev_done;
  logic             st_we, st_re;
  logic [AddrW-1:0] st_waddr, st_raddr;
  logic [WordW-1:0] rd_word;
  event_t           ev;
  cnt_vec_t         counts;

  assign adv       = !ev.valid || ev_done;
  assign in_tready = adv;
  assign accept    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  cpbc_walker #(
    .Slots    (Slots),
    .AddrW    (AddrW),
    .BaseLimit(BaseLimit)
  ) u_walker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .accept     (accept),
    .adv        (adv),
    .command    (in_tuser),
    .align_start(in_tdata[30:0]),
    .map_quality(in_tdata[38:31]),
    .read_flags (in_tdata[54:39]),
    .word_index (in_tdata[58:55]),
    .op_code    (in_tdata[126:123]),
    .op_length  (in_tdata[154:127]),
    .st_we      (st_we),
    .st_waddr   (st_waddr),
    .st_re      (st_re),
    .st_raddr   (st_raddr),
    .ev         (ev)
  );

  cpbc_seq_store #(
    .Slots(Slots),
    .AddrW(AddrW)
  ) u_store (
    .clk  (clk),
    .we   (st_we),
    .waddr(st_waddr),
    .wdata(in_tdata[122:59]),
    .re   (st_re),
    .raddr(st_raddr),
    .rdata(rd_word)
  );

  cpbc_counters u_counters (
    .clk       (clk),
    .rst_n     (rst_n),
    .ev        (ev),
    .rd_word   (rd_word),
    .ev_done   (ev_done),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_counts(counts)
  );

  assign out_tdata = counts;

endmodule
`default_nettype wire

// File: rtl/cpbc_checker.sv
// Port-level checker for the pileup base counter, bound to the top level.
`default_nettype none
`include "assert_macros.svh"
module cpbc_checker (
  input wire logic         clk,
  input wire logic         rst_n,
  input wire logic         in_tready,
  input wire logic         out_tvalid,
  input wire logic         out_tready,
  input wire logic [255:0] out_tdata
);

  `ASSERT_PROP(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid)
  `ASSERT_PROP(a_out_stable, clk, rst_n, out_tvalid && !out_tready |=> $stable(out_tdata))
  `ASSERT_PROP(a_stall_cause, clk, rst_n, !in_tready |-> out_tvalid && !out_tready)
  `ASSERT_NEVER(a_a_le_cov, clk, rst_n, out_tvalid && (out_tdata[31:0] > out_tdata[223:192]))
  `ASSERT_NEVER(a_t_le_cov, clk, rst_n, out_tvalid && (out_tdata[127:96] > out_tdata[223:192]))

endmodule

bind cigar_pileup_base_counter cpbc_checker u_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tready (in_tready),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata)
);
`default_nettype wire

// File: dv/cigar_pileup_base_counter_test.sv
// Self-checking testbench of the pileup base counter: read streams against a built-in tally.
module cigar_pileup_base_counter_test;
  timeunit 1ns;
  timeprecision 1ps;

  import cpbc_pkg::*;

  localparam int ReadBases = 256;
  localparam int RandomItems = 1350;
  localparam int Phases = 8;
  localparam int QuietCycles = 8;
  localparam int HoldCycles = 400;

  localparam logic [3:0] OP_H = 4'd5;
  localparam logic [3:0] OP_P = 4'd6;
  localparam logic [3:0] OP_TOP = 4'd15;
  localparam logic [1:0] CFG_SPARE = 2'd3;

  typedef struct packed {
    logic [27:0] len;
    logic [3:0]  op;
    logic [63:0] word;
    logic [3:0]  widx;
    logic [15:0] flags;
    logic [7:0]  mq;
    logic [30:0] start;
  } fields_t;

  typedef struct packed {
    logic [1:0] cmd;
    fields_t    f;
  } item_t;

  class pileup_tally;
    bit [30:0]  target;
    bit [7:0]   min_mq;
    bit [15:0]  rej_mask;
    bit [31:0]  ref_pos;
    bit [31:0]  read_off;
    bit         skip;
    bit [63:0]  seq_words[16];
    bit [31:0]  tally[NumCnt];
    bit [255:0] owed_counts[$];
    int         errors;

    function new();
      skip = 1'b1;
    endfunction

    function int pending();
      return owed_counts.size();
    endfunction

    function void bump(int which);
      if (tally[which] != '1) tally[which]++;
    endfunction

    function bit [31:0] sat_add(bit [31:0] a, bit [27:0] b);
      bit [32:0] s;
      s = {1'b0, a} + {5'b0, b};
      return s[32] ? '1 : s[31:0];
    endfunction

    function void write_reg(bit [1:0] idx, bit [31:0] data);
      case (idx)
        CFG_TARGET:  target = data[30:0];
        CFG_MIN_MQ:  min_mq = data[7:0];
        CFG_REJ_MSK: rej_mask = data[15:0];
        default: ;
      endcase
    endfunction

    function void walk(bit [3:0] op, bit [27:0] len);
      bit              hit;
      longint unsigned pos;
      bit [63:0]       chunk;
      bit [3:0]        code;
      hit = ({1'b0, ref_pos} <= {2'b0, target}) &&
            ({2'b0, target} < {1'b0, ref_pos} + {5'b0, len});
      case (op)
        OP_M, OP_EQ, OP_X: begin
          if (hit) begin
            pos = read_off;
            pos += {1'b0, target} - ref_pos;
            code = 4'd0;
            if (pos < ReadBases) begin
              chunk = seq_words[int'(pos / 16)];
              code = chunk[(15 - int'(pos % 16)) * 4 +: 4];
            end
            if (code == BASE_A) bump(CNT_A);
            else if (code == BASE_C) bump(CNT_C);
            else if (code == BASE_G) bump(CNT_G);
            else if (code == BASE_T) bump(CNT_T);
            bump(CNT_COV);
          end
          ref_pos = sat_add(ref_pos, len);
          read_off = sat_add(read_off, len);
        end
        OP_I: begin
          if ({1'b0, target} == ref_pos) bump(CNT_INS);
          read_off = sat_add(read_off, len);
        end
        OP_D: begin
          if (hit) bump(CNT_DEL);
          ref_pos = sat_add(ref_pos, len);
        end
        OP_N: ref_pos = sat_add(ref_pos, len);
        OP_S: read_off = sat_add(read_off, len);
        default: ;
      endcase
    endfunction

    function void note_item(bit [1:0] cmd, fields_t f);
      bit [255:0] snap;
      case (cmd)
        CMD_START: begin
          bump(CNT_SEEN);
          ref_pos = {1'b0, f.start};
          read_off = '0;
          skip = (f.mq < min_mq) || ((f.flags & rej_mask) != 16'd0);
        end
        CMD_LOAD: seq_words[f.widx] = f.word;
        CMD_CIGAR: if (!skip) walk(f.op, f.len);
        CMD_REPORT: begin
          for (int i = 0; i < NumCnt; i++) begin
            snap[i * CntW +: CntW] = tally[i];
            tally[i] = '0;
          end
          owed_counts.push_back(snap);
        end
        default: ;
      endcase
    endfunction

    function string field_name(int i);
      case (i)
        CNT_A:   return "count_a";
        CNT_C:   return "count_c";
        CNT_G:   return "count_g";
        CNT_T:   return "count_t";
        CNT_INS: return "count_ins";
        CNT_DEL: return "count_del";
        CNT_COV: return "covered_reads";
        default: return "reads_seen";
      endcase
    endfunction

    function void check_result(logic [255:0] got);
      bit [255:0] want;
      if (owed_counts.size() == 0) begin
        $display("%0t: unexpected report, expected none, actual %h", $time, got);
        errors++;
        return;
      end
      want = owed_counts.pop_front();
      for (int i = 0; i < NumCnt; i++) begin
        if (got[i * CntW +: CntW] !== want[i * CntW +: CntW]) begin
          $display("%0t: %s expected %0d actual %0d", $time, field_name(i),
                   want[i * CntW +: CntW], got[i * CntW +: CntW]);
          errors++;
        end
      end
    endfunction
  endclass

  logic         clk;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [159:0] in_tdata = '0;
  logic [1:0]   in_tuser = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [255:0] out_tdata;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [1:0]   cfg_index = '0;
  logic [31:0]  cfg_data = '0;

  pileup_tally  pileup;
  logic [30:0]  tgt;
  logic [7:0]   minq;
  logic [15:0]  rmask;
  int unsigned  fed;
  int unsigned  burst_left;
  bit           steady;
  bit           hold_req;

  cigar_pileup_base_counter #(
    .MAX_READ_BASES(ReadBases)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("[cigar_pileup_base_counter] ERROR");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) pileup.write_reg(cfg_index, cfg_data);
      if (in_tvalid && in_tready) pileup.note_item(in_tuser, in_tdata[154:0]);
      if (out_tvalid && out_tready) pileup.check_result(out_tdata);
    end
  end

  initial begin : drain_side
    int          seg;
    int          mode;
    int unsigned beat;
    beat = 0;
    forever begin
      seg = $urandom_range(10, 150);
      mode = $urandom_range(0, 3);
      repeat (seg) begin
        @(posedge clk);
        if (hold_req) begin
          hold_req = 1'b0;
          out_tready <= 1'b0;
          repeat (HoldCycles) @(posedge clk);
        end
        case (mode)
          0: out_tready <= 1'b1;
          1: out_tready <= 1'($urandom_range(0, 1));
          2: out_tready <= (beat % 5) != 0;
          default: out_tready <= ($urandom_range(0, 4) == 0);
        endcase
        beat++;
      end
    end
  end

  function automatic item_t rand_item();
    item_t        it;
    logic [159:0] r;
    r = {$urandom, $urandom, $urandom, $urandom, $urandom};
    it.cmd = 2'($urandom);
    it.f = r[154:0];
    return it;
  endfunction

  function automatic item_t mk_start(logic [30:0] a, logic [7:0] q, logic [15:0] fl);
    item_t it;
    it = rand_item();
    it.cmd = CMD_START;
    it.f.start = a;
    it.f.mq = q;
    it.f.flags = fl;
    return it;
  endfunction

  function automatic item_t mk_load(logic [3:0] idx, logic [63:0] w);
    item_t it;
    it = rand_item();
    it.cmd = CMD_LOAD;
    it.f.widx = idx;
    it.f.word = w;
    return it;
  endfunction

  function automatic item_t mk_op(logic [3:0] op, logic [27:0] len);
    item_t it;
    it = rand_item();
    it.cmd = CMD_CIGAR;
    it.f.op = op;
    it.f.len = len;
    return it;
  endfunction

  function automatic item_t mk_report();
    item_t it;
    it = rand_item();
    it.cmd = CMD_REPORT;
    return it;
  endfunction

  function automatic logic [63:0] rand_word();
    logic [63:0] w;
    for (int k = 0; k < 16; k++) begin
      case ($urandom_range(0, 8))
        0, 1: w[k * 4 +: 4] = BASE_A;
        2, 3: w[k * 4 +: 4] = BASE_C;
        4, 5: w[k * 4 +: 4] = BASE_G;
        6, 7: w[k * 4 +: 4] = BASE_T;
        default: w[k * 4 +: 4] = 4'($urandom);
      endcase
    end
    return w;
  endfunction

  function automatic logic [3:0] pick_op();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 35) return OP_M;
    if (r < 45) return OP_I;
    if (r < 55) return OP_D;
    if (r < 60) return OP_N;
    if (r < 70) return OP_S;
    if (r < 78) return OP_EQ;
    if (r < 86) return OP_X;
    if (r < 90) return OP_H;
    if (r < 94) return OP_P;
    return 4'($urandom_range(OP_X + 1, OP_TOP));
  endfunction

  function automatic logic [27:0] rand_len();
    case ($urandom_range(0, 19))
      0: return '0;
      1: return 28'($urandom);
      2: return 28'($urandom_range(100, 300));
      default: return 28'($urandom_range(1, 30));
    endcase
  endfunction

  task automatic push(item_t it);
    if (burst_left == 0) begin
      burst_left = steady ? 1000 : $urandom_range(1, 40);
      if (!steady && $urandom_range(0, 3) != 0) begin
        in_tvalid <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
    end
    burst_left--;
    fed++;
    in_tvalid <= 1'b1;
    in_tdata <= {5'd0, it.f};
    in_tuser <= it.cmd;
    do @(posedge clk); while (in_tready !== 1'b1);
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pileup.pending() != 0) @(posedge clk);
    repeat (QuietCycles) @(posedge clk);
  endtask

  task automatic configure(logic [30:0] t, logic [7:0] q, logic [15:0] m);
    logic [1:0]  regs[4];
    logic [31:0] vals[4];
    regs = '{CFG_TARGET, CFG_MIN_MQ, CFG_REJ_MSK, CFG_SPARE};
    vals[0] = {1'($urandom), t};
    vals[1] = {24'($urandom), q};
    vals[2] = {16'($urandom), m};
    vals[3] = $urandom;
    for (int k = 0; k < 4; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= regs[k];
      cfg_data <= vals[k];
      do @(posedge clk); while (cfg_ready !== 1'b1);
    end
    cfg_valid <= 1'b0;
    tgt = t;
    minq = q;
    rmask = m;
  endtask

  task automatic send_read();
    int unsigned back;
    int unsigned nops;
    logic [30:0] st;
    logic [7:0]  q;
    logic [15:0] fl;
    bit          runaway;
    runaway = ($urandom_range(0, 39) == 0);
    back = $urandom_range(0, 60);
    if (runaway || $urandom_range(0, 9) == 0) st = 31'($urandom);
    else st = (tgt > back) ? tgt - 31'(back) : '0;
    q = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(minq, 255));
    fl = 16'($urandom);
    if ($urandom_range(0, 2) != 0) fl = fl & ~rmask;
    repeat ($urandom_range(0, 3)) push(mk_load(4'($urandom), rand_word()));
    push(mk_start(st, q, fl));
    nops = runaway ? 24 : $urandom_range(1, 8);
    repeat (nops) begin
      if ($urandom_range(0, 19) == 0) push(mk_load(4'($urandom), rand_word()));
      if ($urandom_range(0, 29) == 0) push(mk_report());
      push(mk_op(pick_op(), runaway ? '1 - 28'($urandom_range(0, 3)) : rand_len()));
    end
    if ($urandom_range(0, 3) == 0) push(mk_report());
  endtask

  initial begin : stimulus
    int unsigned stop_at;
    pileup = new();
    fed = 0;
    burst_left = 0;
    steady = 1'b0;
    hold_req = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    configure(31'd20, 8'd30, 16'h0004);
    for (int i = 0; i < 16; i++) begin
      push(mk_load(4'(i), (i == 15) ? '1 : (i == 7) ? '0 : rand_word()));
    end

    push(mk_op(OP_M, 28'd50));
    push(mk_report());
    push(mk_start(31'd10, 8'd30, 16'hFFFB));
    push(mk_op(OP_S, 28'd3));
    push(mk_op(OP_M, 28'd5));
    push(mk_op(OP_I, 28'd2));
    push(mk_op(OP_H, 28'd7));
    push(mk_op(OP_P, 28'd4));
    push(mk_op(OP_TOP, '1));
    push(mk_op(OP_D, 28'd5));
    push(mk_op(OP_I, 28'd1));
    push(mk_op(OP_EQ, 28'd1));
    push(mk_op(OP_X, 28'd0));
    push(mk_report());
    push(mk_start(31'd20, 8'd29, 16'h0000));
    push(mk_op(OP_M, 28'd10));
    push(mk_start(31'd0, 8'd255, 16'h0004));
    push(mk_op(OP_M, 28'd10));
    push(mk_start(31'd18, 8'd255, 16'h0000));
    push(mk_op(OP_D, 28'd5));
    push(mk_op(OP_N, 28'd0));
    push(mk_start(31'd5, 8'd200, 16'h0000));
    push(mk_op(OP_S, 28'd255));
    push(mk_op(OP_M, 28'd30));
    push(mk_start('1, 8'd255, 16'h0000));
    push(mk_op(OP_M, '1));
    push(mk_report());

    for (int ph = 0; ph < Phases; ph++) begin
      settle();
      case (ph)
        0: configure('0, '0, '0);
        1: configure('1, '1, '1);
        2: configure('1, '0, '0);
        default: configure(($urandom_range(0, 3) == 0) ? 31'($urandom)
                                                        : 31'($urandom_range(0, 4000)),
                           8'($urandom_range(0, 60)), 16'($urandom & $urandom));
      endcase
      burst_left = 0;
      steady = (ph == 3);
      if (ph == 2) begin
        steady = 1'b1;
        hold_req = 1'b1;
        repeat (12) begin
          push(mk_report());
          push(mk_op(OP_M, 28'd1));
        end
        steady = 1'b0;
        burst_left = 0;
      end
      stop_at = fed + RandomItems / Phases;
      while (fed < stop_at) begin
        if ($urandom_range(0, 11) == 0) push(rand_item());
        else send_read();
      end
      steady = 1'b0;
    end

    push(mk_report());
    settle();
    if (pileup.errors == 0 && pileup.pending() == 0) begin
      $display("[cigar_pileup_base_counter] OK");
    end else begin
      $display("[cigar_pileup_base_counter] ERROR");
    end
    $finish;
  end

endmodule
